/* rtl/core/mcss_pkg.sv */
`default_nettype none

package mcss_pkg;

  localparam int unsigned PITCH_CLASSES = 12;
  localparam int unsigned NOTE_W        = 4;
  localparam int unsigned STATE_W       = 2;
  localparam int unsigned RAND_W        = 16;
  localparam int unsigned WEIGHT_W      = 17;
  localparam int unsigned CDF_W         = 17;
  localparam int unsigned ROM_COLS      = 4;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_HARM_FIRST  = 2'd0;
  localparam cfg_idx_t CFG_HARM_SECOND = 2'd1;
  localparam cfg_idx_t CFG_HARM_THIRD  = 2'd2;

  localparam logic [WEIGHT_W-1:0] HARM_FIRST_RST  = 17'd32768;
  localparam logic [WEIGHT_W-1:0] HARM_SECOND_RST = 17'd19661;
  localparam logic [WEIGHT_W-1:0] HARM_THIRD_RST  = 17'd13107;

  // Harmony intervals in semitones above the main note.
  localparam logic [NOTE_W:0] HARM_STEP_FIRST  = 5'd4;
  localparam logic [NOTE_W:0] HARM_STEP_SECOND = 5'd6;
  localparam logic [NOTE_W:0] HARM_STEP_THIRD  = 5'd8;

  typedef logic [PITCH_CLASSES-1:0][CDF_W-1:0] pitch_cdf_t;
  typedef logic [ROM_COLS-1:0][CDF_W-1:0]      row_cdf_t;
  typedef row_cdf_t [ROM_COLS-1:0]             rom_cdf_t;

  // Running Q1.16 sums of the transition rows; element 0 is the first column.
  localparam pitch_cdf_t PITCH_CDF_FROM_C = {
    17'd65538, 17'd65538, 17'd65538, 17'd65538, 17'd65538, 17'd65538,
    17'd58984, 17'd52430, 17'd45876, 17'd39322, 17'd32768, 17'd13107
  };
  localparam pitch_cdf_t PITCH_CDF_OTHER = {
    17'd65537, 17'd65537, 17'd65537, 17'd65537, 17'd65537, 17'd65537,
    17'd58983, 17'd58983, 17'd52429, 17'd39322, 17'd26215, 17'd19661
  };
  localparam pitch_cdf_t PITCH_CDF_ZERO = '0;

  localparam rom_cdf_t OCTAVE_CDF = {
    {17'd0,     17'd0,     17'd0,     17'd0},
    {17'd65536, 17'd65536, 17'd32768, 17'd13107},
    {17'd65536, 17'd65536, 17'd45875, 17'd19661},
    {17'd65536, 17'd65536, 17'd52429, 17'd32768}
  };
  localparam rom_cdf_t DURATION_CDF = {
    {17'd0,     17'd0,     17'd0,     17'd0},
    {17'd65536, 17'd65536, 17'd19661, 17'd6554},
    {17'd65536, 17'd65536, 17'd45875, 17'd13107},
    {17'd65537, 17'd65537, 17'd58983, 17'd39322}
  };

  typedef struct packed {
    logic [RAND_W-1:0] rand_note;
    logic [RAND_W-1:0] rand_octave;
    logic [RAND_W-1:0] rand_first_harmony;
    logic [RAND_W-1:0] rand_second_harmony;
    logic [RAND_W-1:0] rand_length;
  } item_t;

  typedef struct packed {
    logic [NOTE_W-1:0]  note_out;
    logic [STATE_W-1:0] octave_out;
    logic [NOTE_W-1:0]  first_harmony_out;
    logic [NOTE_W-1:0]  second_harmony_out;
    logic [STATE_W-1:0] length_out;
  } chord_t;

  typedef struct packed {
    logic [NOTE_W-1:0]  pitch;
    logic [STATE_W-1:0] octave;
    logic [STATE_W-1:0] duration;
  } chain_state_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] first;
    logic [WEIGHT_W-1:0] second;
    logic [WEIGHT_W-1:0] third;
  } harm_weights_t;

endpackage

`default_nettype wire

/* rtl/core/mcss_stream_if.sv */
`default_nettype none

interface mcss_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/mcss_cfg.sv */
`default_nettype none

module mcss_cfg (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               cfg_we_i,
  input  mcss_pkg::cfg_idx_t                cfg_idx_i,
  input  wire [mcss_pkg::WEIGHT_W-1:0]      cfg_data_i,
  output mcss_pkg::harm_weights_t           weights_o
);
  import mcss_pkg::*;

  harm_weights_t weights_d, weights_q;

  always_comb begin
    weights_d = weights_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HARM_FIRST:  weights_d.first  = cfg_data_i;
        CFG_HARM_SECOND: weights_d.second = cfg_data_i;
        CFG_HARM_THIRD:  weights_d.third  = cfg_data_i;
        default:         weights_d = weights_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weights_q.first  <= HARM_FIRST_RST;
      weights_q.second <= HARM_SECOND_RST;
      weights_q.third  <= HARM_THIRD_RST;
    end else begin
      weights_q <= weights_d;
    end
  end

  assign weights_o = weights_q;

endmodule

`default_nettype wire

/* rtl/core/mcss_draw.sv */
`default_nettype none

module mcss_draw #(
  parameter int unsigned OCTAVE_STATES   = 3,
  parameter int unsigned DURATION_STATES = 3
) (
  input  mcss_pkg::chain_state_t  state_i,
  input  mcss_pkg::item_t         item_i,
  input  mcss_pkg::harm_weights_t weights_i,
  output mcss_pkg::chain_state_t  state_o,
  output mcss_pkg::chord_t        chord_o
);
  import mcss_pkg::*;

  // Inverse CDF over a pitch row: first column whose running sum exceeds r.
  function automatic logic [NOTE_W-1:0] pick_pitch(pitch_cdf_t cdf, logic [RAND_W-1:0] r);
    logic [NOTE_W-1:0] idx;
    idx = NOTE_W'(PITCH_CLASSES - 1);
    for (int i = PITCH_CLASSES - 1; i >= 0; i--) begin
      if ({1'b0, r} < cdf[i]) idx = NOTE_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [STATE_W-1:0] pick_state(row_cdf_t cdf, int unsigned n,
                                                     logic [RAND_W-1:0] r);
    logic [STATE_W-1:0] idx;
    idx = STATE_W'(n - 1);
    for (int i = ROM_COLS - 1; i >= 0; i--) begin
      if (i < int'(n) && {1'b0, r} < cdf[i]) idx = STATE_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [NOTE_W-1:0] add_mod12(logic [NOTE_W-1:0] note,
                                                   logic [NOTE_W:0] step);
    logic [NOTE_W:0] sum;
    sum = {1'b0, note} + step;
    if (sum >= (NOTE_W+1)'(PITCH_CLASSES)) sum = sum - (NOTE_W+1)'(PITCH_CLASSES);
    return sum[NOTE_W-1:0];
  endfunction

  localparam int unsigned SUM_W = WEIGHT_W + 2;

  pitch_cdf_t         pitch_row;
  logic [NOTE_W-1:0]  note;
  logic [SUM_W-1:0]   cum_first, cum_second, cum_third;

  always_comb begin
    if (state_i.pitch == '0) begin
      pitch_row = PITCH_CDF_FROM_C;
    end else if (state_i.pitch < NOTE_W'(PITCH_CLASSES)) begin
      pitch_row = PITCH_CDF_OTHER;
    end else begin
      pitch_row = PITCH_CDF_ZERO;
    end
  end

  assign note = pick_pitch(pitch_row, item_i.rand_note);

  assign cum_first  = SUM_W'(weights_i.first);
  assign cum_second = cum_first + SUM_W'(weights_i.second);
  assign cum_third  = cum_second + SUM_W'(weights_i.third);

  function automatic logic [NOTE_W-1:0] pick_harmony(logic [NOTE_W-1:0] base,
                                                      logic [RAND_W-1:0] r,
                                                      logic [SUM_W-1:0] c0,
                                                      logic [SUM_W-1:0] c1,
                                                      logic [SUM_W-1:0] c2);
    logic [SUM_W-1:0] rx;
    logic [NOTE_W:0]  step;
    rx = SUM_W'(r);
    if (rx < c0) begin
      step = HARM_STEP_FIRST;
    end else if (rx < c1) begin
      step = HARM_STEP_SECOND;
    end else if (rx < c2) begin
      step = HARM_STEP_THIRD;
    end else begin
      step = HARM_STEP_FIRST;
    end
    return add_mod12(base, step);
  endfunction

  always_comb begin
    state_o.pitch    = note;
    state_o.octave   = pick_state(OCTAVE_CDF[state_i.octave], OCTAVE_STATES,
                                  item_i.rand_octave);
    state_o.duration = pick_state(DURATION_CDF[state_i.duration], DURATION_STATES,
                                  item_i.rand_length);

    chord_o.note_out           = note;
    chord_o.octave_out         = state_o.octave;
    chord_o.first_harmony_out  = pick_harmony(note, item_i.rand_first_harmony,
                                              cum_first, cum_second, cum_third);
    chord_o.second_harmony_out = pick_harmony(note, item_i.rand_second_harmony,
                                              cum_first, cum_second, cum_third);
    chord_o.length_out         = state_o.duration;
  end

endmodule

`default_nettype wire

/* rtl/core/markov_chord_step_sampler.sv */
// Markov chord sampler: one chord out for every item of five random fractions in.
//
// item_i (sink) takes the five 16-bit uniform fractions, chord_o (source) delivers
// note, octave, two harmony pitch classes and length. A transaction completes on
// a rising edge with valid and ready both high. The three harmony weights are
// written through cfg_we_i / cfg_idx_i / cfg_data_i by the user only while the
// block is idle; the block itself does not enforce it. Indexes past the third are ignored.
//
// An item lands in an input register, all draws are resolved by combinational
// constant-table compares against the note/octave/length state, and the chord
// is captured in the output register once that register is empty or being taken.
// One item per cycle is sustained while chord_o is ready; the draw logic in the
// loop through the state registers is purely combinational.
// When chord_o stalls, the output register holds and the input register still
// takes one more item; after that item_i.ready drops until the chord is taken.
// Reset clears the valid flags of both registers, sets the state to note C,
// octave 1, duration state 0 and loads the default harmony weights.
`default_nettype none

module markov_chord_step_sampler #(
  parameter int unsigned OCTAVE_STATES   = 3,
  parameter int unsigned DURATION_STATES = 3
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  mcss_stream_if.sink                   item_i,
  mcss_stream_if.source                 chord_o,
  input  wire                           cfg_we_i,
  input  mcss_pkg::cfg_idx_t            cfg_idx_i,
  input  wire [mcss_pkg::WEIGHT_W-1:0]  cfg_data_i
);
  import mcss_pkg::*;

  harm_weights_t weights;
  chain_state_t  state_d, state_q;
  chord_t        chord_d, chord_q;
  item_t         in_data_q;
  logic          in_valid_d, in_valid_q;
  logic          out_valid_d, out_valid_q;
  logic          advance;
  logic          take_item;

  mcss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .weights_o  (weights)
  );

  mcss_draw #(
    .OCTAVE_STATES   (OCTAVE_STATES),
    .DURATION_STATES (DURATION_STATES)
  ) u_draw (
    .state_i   (state_q),
    .item_i    (in_data_q),
    .weights_i (weights),
    .state_o   (state_d),
    .chord_o   (chord_d)
  );

  assign advance       = in_valid_q && (!out_valid_q || chord_o.ready);
  assign item_i.ready  = !in_valid_q || advance;
  assign take_item     = item_i.valid && item_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (take_item) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (chord_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      state_q.pitch    <= '0;
      state_q.octave   <= STATE_W'(1);
      state_q.duration <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_item) begin
      in_data_q <= item_i.data;
    end
    if (advance) begin
      chord_q <= chord_d;
    end
  end

  assign chord_o.valid = out_valid_q;
  assign chord_o.data  = chord_q;

  // The delivered chord always carries the state it left behind.
  a_chord_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (chord_o.data.note_out == state_q.pitch) &&
                (chord_o.data.octave_out == state_q.octave) &&
                (chord_o.data.length_out == state_q.duration))
    else $error("chord does not match chain state");

  // A stalled output freezes the chain.
  a_state_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !chord_o.ready) |=> $stable(state_q))
    else $error("chain state moved while output stalled");

  a_pitch_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pitch < NOTE_W'(PITCH_CLASSES))
    else $error("pitch state out of range");

  a_octave_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, state_q.octave} < 3'(OCTAVE_STATES))
    else $error("octave state out of range");

endmodule

`default_nettype wire
